// ----- src/fou_pkg.sv -----
// Shared types and helpers for the first-occurrence unique-value filter.
// Used by fou_ctrl, fou_datapath and the top level; depends on nothing.
package fou_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned COUNT_OUT_W = 7;

    localparam logic [VALUE_W-1:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
    localparam logic [VALUE_W-1:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input item, restart the table scan
        logic rd_en;    // read the next table entry
        logic idx_inc;  // advance the scan index
        logic emit;     // drive one result
        logic append;   // store the value as a new entry
        logic drop;     // value is new but the table is full
    } t_fou_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;
        logic idx_last;
        logic match;
        logic full;
    } t_fou_status;

    function automatic logic f_is_nan(input logic [VALUE_W-1:0] v);
        f_is_nan = ((v & EXP_MASK) == EXP_MASK) && ((v & FRAC_MASK) != '0);
    endfunction

    // IEEE equality: NaN never matches, and the two zeros match each other.
    function automatic logic f_ieee_eq(input logic [VALUE_W-1:0] a,
                                       input logic [VALUE_W-1:0] b);
        if (f_is_nan(a) || f_is_nan(b)) begin
            f_ieee_eq = 1'b0;
        end else if (((a & MAG_MASK) == '0) && ((b & MAG_MASK) == '0)) begin
            f_ieee_eq = 1'b1;
        end else begin
            f_ieee_eq = (a == b);
        end
    endfunction

endpackage

// ----- src/fou_ctrl.sv -----
// Controller state machine for the unique-value filter.
// Depends on fou_pkg for the command and status structs.
module fou_ctrl
    import fou_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_fou_status i_status,
    output t_fou_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.cnt_zero) begin
                    // Empty table: the value is new by definition.
                    o_cmd.emit   = 1'b1;
                    o_cmd.append = !i_status.full;
                    o_cmd.drop   = i_status.full;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (i_status.match) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_status.idx_last) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.append = !i_status.full;
                    o_cmd.drop   = i_status.full;
                    n_state      = S_IDLE;
                end else begin
                    // Read the following entry while this one is compared.
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not make the block busy");

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> !busy)
        else $error("controller still busy after emitting a result");

endmodule

// ----- src/fou_datapath.sv -----
// Datapath of the unique-value filter: input capture, table memory,
// scan index, IEEE compare and result registers. Depends on fou_pkg.
module fou_datapath
    import fou_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_W-1:0]     i_value,
    input  logic                   i_start_req,
    input  logic                   i_last,
    input  t_fou_cmd               i_cmd,
    output t_fou_status            o_status,
    output logic                   o_done,
    output logic [VALUE_W-1:0]     o_value_out,
    output logic                   o_is_new,
    output logic [COUNT_OUT_W-1:0] o_distinct_count,
    output logic                   o_dropped,
    output logic                   o_last_out
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] r_rd_data;
    logic [VALUE_W-1:0] r_value;
    logic               r_last;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      n_idx;
    logic [CW-1:0]      n_count;
    logic               r_done;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_is_new;
    logic               r_out_dropped;
    logic               r_out_last;
    logic [CW-1:0]      r_out_count;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    assign n_idx   = i_cmd.idx_inc ? (r_idx + AW'(1)) : r_idx;
    assign n_count = r_count + CW'(1);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
            if (i_cmd.load && i_start_req) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= n_count;
            end
        end
    end

    // Item capture and scan index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_last  <= i_last;
            r_idx   <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[r_count[AW-1:0]] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[n_idx];
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_value   <= r_value;
            r_out_is_new  <= i_cmd.append;
            r_out_dropped <= i_cmd.drop;
            r_out_last    <= r_last;
            r_out_count   <= i_cmd.append ? n_count : r_count;
        end
    end

    assign o_status.cnt_zero = (r_count == '0);
    assign o_status.idx_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_status.match    = f_ieee_eq(r_value, r_rd_data);
    assign o_status.full     = (r_count == DEPTH_C);

    assign count_ext        = {{COUNT_OUT_W{1'b0}}, r_out_count};
    assign o_done           = r_done;
    assign o_value_out      = r_out_value;
    assign o_is_new         = r_out_is_new;
    assign o_dropped        = r_out_dropped;
    assign o_last_out       = r_out_last;
    assign o_distinct_count = count_ext[COUNT_OUT_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("stored count exceeds the table depth");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (r_count < DEPTH_C))
        else $error("append issued with a full table");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !(r_out_is_new && r_out_dropped))
        else $error("result flagged both new and dropped");

endmodule

// ----- src/first_occurrence_unique.sv -----
// Top level of the first-occurrence unique-value filter for IEEE doubles.
// Instantiates fou_ctrl and fou_datapath; depends on fou_pkg.
//
// Each item is accepted when start is high and busy is low. It is compared,
// one stored entry per cycle through the table memory's single read port,
// against the distinct values held so far, and then one result appears for
// exactly one cycle with o_done high; the receiver cannot stall it. An item
// that meets N stored entries before a match or the end of the table keeps
// busy high through the check state and N passes of the compare state (only
// the check state when the table is empty), with N up to TABLE_DEPTH. o_done
// is high in the first cycle in which busy is low again, which is also the
// earliest cycle whose closing edge can accept the next item. The table memory
// needs no clearing after reset; i_start_req empties it for a new set.
module first_occurrence_unique
    import fou_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_W-1:0]     i_value,
    input  logic                   i_start_req,
    input  logic                   i_last,
    output logic                   o_done,
    output logic [VALUE_W-1:0]     o_value_out,
    output logic                   o_is_new,
    output logic [COUNT_OUT_W-1:0] o_distinct_count,
    output logic                   o_dropped,
    output logic                   o_last_out
);

    t_fou_cmd    cmd;
    t_fou_status status;

    fou_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    fou_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_value          (i_value),
        .i_start_req      (i_start_req),
        .i_last           (i_last),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_done           (o_done),
        .o_value_out      (o_value_out),
        .o_is_new         (o_is_new),
        .o_distinct_count (o_distinct_count),
        .o_dropped        (o_dropped),
        .o_last_out       (o_last_out)
    );

endmodule

// ----- tb/first_occurrence_unique_checker.sv -----
// Checker for the first-occurrence unique-value filter: watches the input and result ports,
// keeps its own distinct-value table, and compares every result with its prediction.
// Depends on fou_pkg for the value and count widths.
module first_occurrence_unique_checker
    import fou_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic [VALUE_W-1:0]     i_value,
    input  logic                   i_start_req,
    input  logic                   i_last,
    input  logic                   i_done,
    input  logic [VALUE_W-1:0]     i_value_out,
    input  logic                   i_is_new,
    input  logic [COUNT_OUT_W-1:0] i_distinct_count,
    input  logic                   i_dropped,
    input  logic                   i_last_out,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [VALUE_W-1:0]     value;
        logic                   is_new;
        logic [COUNT_OUT_W-1:0] count;
        logic                   dropped;
        logic                   last;
    } t_dedup_result;

    t_dedup_result      awaited_results [$];
    t_dedup_result      want;
    t_dedup_result      fresh;
    logic [VALUE_W-1:0] kept_values [TABLE_DEPTH];
    int unsigned        kept_count = 0;

    function automatic logic nan_pattern(input logic [VALUE_W-1:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] != '0);
    endfunction

    // Equality on doubles: NaN matches nothing and the two zeros match each other.
    function automatic logic same_number(input logic [VALUE_W-1:0] a,
                                         input logic [VALUE_W-1:0] b);
        if (nan_pattern(a) || nan_pattern(b)) begin
            return 1'b0;
        end
        if ((a[62:0] == '0) && (b[62:0] == '0)) begin
            return 1'b1;
        end
        return a == b;
    endfunction

    task automatic dedup_predict(input logic [VALUE_W-1:0] v, input logic sr,
                                 input logic lst, output t_dedup_result res);
        logic hit;
        hit = 1'b0;
        if (sr) begin
            kept_count = 0;
        end
        for (int unsigned i = 0; i < kept_count; i++) begin
            if (!hit && same_number(v, kept_values[i])) begin
                hit = 1'b1;
            end
        end
        res.value   = v;
        res.last    = lst;
        res.is_new  = 1'b0;
        res.dropped = 1'b0;
        if (!hit) begin
            if (kept_count < TABLE_DEPTH) begin
                kept_values[kept_count] = v;
                kept_count++;
                res.is_new = 1'b1;
            end else begin
                res.dropped = 1'b1;
            end
        end
        res.count = COUNT_OUT_W'(kept_count);
    endtask

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] exp_val);
        $display("MISMATCH %s: got %h, expected %h", what, got, exp_val);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_results.delete();
            kept_count = 0;
        end else begin
            // The result of an earlier transfer is checked before a new transfer is predicted.
            if (i_done === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing pending", i_value_out, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_value_out !== want.value)
                        report_mismatch("value_out", i_value_out, want.value);
                    if (i_is_new !== want.is_new)
                        report_mismatch("is_new", i_is_new, want.is_new);
                    if (i_distinct_count !== want.count)
                        report_mismatch("distinct_count", i_distinct_count, want.count);
                    if (i_dropped !== want.dropped)
                        report_mismatch("dropped", i_dropped, want.dropped);
                    if (i_last_out !== want.last)
                        report_mismatch("last_out", i_last_out, want.last);
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                dedup_predict(i_value, i_start_req, i_last, fresh);
                awaited_results.push_back(fresh);
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ----- tb/first_occurrence_unique_test.sv -----
// Top of the first-occurrence unique-value filter test: clock, reset and item stimulus.
// Depends on fou_pkg, first_occurrence_unique and first_occurrence_unique_checker.
module first_occurrence_unique_test;
    import fou_pkg::*;

    localparam int unsigned TABLE_DEPTH = 64;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned DIRECTED_ITEMS = 19;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [VALUE_W-1:0]     i_value = '0;
    logic                   i_start_req = 1'b0;
    logic                   i_last = 1'b0;
    logic                   o_done;
    logic [VALUE_W-1:0]     o_value_out;
    logic                   o_is_new;
    logic [COUNT_OUT_W-1:0] o_distinct_count;
    logic                   o_dropped;
    logic                   o_last_out;
    int                     fail_count;
    int                     pending;

    logic [VALUE_W-1:0] set_pool [8];
    int unsigned        random_sent = 0;
    int unsigned        set_no = 0;
    int unsigned        set_len;

    // Zeros of both signs, infinities, NaNs of both kinds and a few ordinary values.
    logic [VALUE_W-1:0] dir_value [DIRECTED_ITEMS] = '{
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
        64'h7FF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'h7FF0_0000_0000_0001,
        64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000,
        64'hBFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h7FF8_0000_0000_0000, 64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA
    };
    logic dir_start_req [DIRECTED_ITEMS] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                             1, 0, 1, 0, 1};
    logic dir_last [DIRECTED_ITEMS] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                                        0, 1, 0, 1, 1};

    first_occurrence_unique #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_value         (i_value),
        .i_start_req     (i_start_req),
        .i_last          (i_last),
        .o_done          (o_done),
        .o_value_out     (o_value_out),
        .o_is_new        (o_is_new),
        .o_distinct_count(o_distinct_count),
        .o_dropped       (o_dropped),
        .o_last_out      (o_last_out)
    );

    first_occurrence_unique_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_value         (i_value),
        .i_start_req     (i_start_req),
        .i_last          (i_last),
        .i_done          (o_done),
        .i_value_out     (o_value_out),
        .i_is_new        (o_is_new),
        .i_distinct_count(o_distinct_count),
        .i_dropped       (o_dropped),
        .i_last_out      (o_last_out),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [VALUE_W-1:0] rand_bits64();
        return {$urandom(), $urandom()};
    endfunction

    // Sets that must overflow the table lean on fresh random values.
    function automatic logic [VALUE_W-1:0] pick_value(input logic fill_table);
        int unsigned r;
        logic [51:0] frac;
        r = $urandom_range(0, 99);
        frac = 52'(rand_bits64());
        if (fill_table && r >= 20) begin
            return rand_bits64();
        end
        if (r < 35) begin
            return set_pool[$urandom_range(0, 7)];
        end else if (r < 45) begin
            return {1'($urandom_range(0, 1)), 63'h0};
        end else if (r < 55) begin
            if (frac == '0) begin
                frac = 52'h1;
            end
            return {1'($urandom_range(0, 1)), 11'h7FF, frac};
        end else if (r < 60) begin
            return {1'($urandom_range(0, 1)), 11'h7FF, 52'h0};
        end
        return rand_bits64();
    endfunction

    // Mostly back-to-back, sometimes a short idle gap, rarely a long stretch.
    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [VALUE_W-1:0] v, input logic sr, input logic lst);
        @(negedge i_clk);
        start       <= 1'b1;
        i_value     <= v;
        i_start_req <= sr;
        i_last      <= lst;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic idle_for(input int unsigned n);
        if (n > 0) begin
            @(negedge i_clk);
            start       <= 1'b0;
            i_value     <= rand_bits64();
            i_start_req <= 1'($urandom_range(0, 1));
            i_last      <= 1'($urandom_range(0, 1));
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ITEMS; i++) begin
            send_item(dir_value[i], dir_start_req[i], dir_last[i]);
            idle_for((i % 4 == 2) ? $urandom_range(1, 5) : 0);
        end
        drain();

        // Sets open with a start request and close with last; a few break that shape.
        while (random_sent < RANDOM_ITEMS) begin
            if (set_no % 12 == 5) begin
                set_len = $urandom_range(TABLE_DEPTH + 2, TABLE_DEPTH + 26);
            end else if ($urandom_range(0, 99) < 85) begin
                set_len = $urandom_range(1, 12);
            end else begin
                set_len = $urandom_range(13, 40);
            end
            foreach (set_pool[i]) begin
                set_pool[i] = rand_bits64();
            end
            for (int unsigned k = 0; k < set_len; k++) begin
                send_item(pick_value(set_len > TABLE_DEPTH),
                          (k == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 39) == 0),
                          (k == set_len - 1) ? ($urandom_range(0, 19) != 0)
                                             : ($urandom_range(0, 39) == 0));
                random_sent++;
                idle_for(random_gap());
            end
            if (set_no % 10 == 3) begin
                drain();
            end
            set_no++;
        end

        drain();
        repeat (TABLE_DEPTH + 8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("first_occurrence_unique_test passed");
        end else begin
            $display("first_occurrence_unique_test failed");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("first_occurrence_unique_test failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/fou_pkg.sv
src/fou_ctrl.sv
src/fou_datapath.sv
src/first_occurrence_unique.sv
tb/first_occurrence_unique_checker.sv
tb/first_occurrence_unique_test.sv
